@@ hw/rtl/imrot_pkg.sv @@
// shared constants and types for the nearest-neighbor rotation frame store
// no dependencies
package imrot_pkg;

  localparam int MAX_SIDE       = 256;
  localparam int PIXEL_BITS     = 32;
  localparam int TRIG_FRAC_BITS = 14;

  localparam int SIDE_BITS  = $clog2(MAX_SIDE);
  localparam int ADDR_BITS  = 2 * SIDE_BITS;
  localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;

  // fixed field widths
  localparam int TRIG_W  = 16;
  localparam int COORD_W = 9;
  localparam int SRC_W   = 9;
  localparam int OUT_W   = 10;
  localparam int D_W     = OUT_W + 1;          // signed 2*coord - out size
  localparam int PROD_W  = TRIG_W + D_W;
  localparam int SUM_W   = PROD_W + 2;
  localparam int CFG_W   = 32;
  localparam int IDX_W   = 3;

  // register indexes
  localparam logic [IDX_W-1:0] CFG_COS      = 3'd0;
  localparam logic [IDX_W-1:0] CFG_SIN      = 3'd1;
  localparam logic [IDX_W-1:0] CFG_SRC_W    = 3'd2;
  localparam logic [IDX_W-1:0] CFG_SRC_H    = 3'd3;
  localparam logic [IDX_W-1:0] CFG_OUT_W    = 3'd4;
  localparam logic [IDX_W-1:0] CFG_OUT_H    = 3'd5;
  localparam logic [IDX_W-1:0] CFG_CLEAR    = 3'd6;

  localparam logic [0:0] FUNC_LOAD  = 1'b0;
  localparam logic [0:0] FUNC_FETCH = 1'b1;

  typedef struct packed {
    logic signed [TRIG_W-1:0] cos_q14;
    logic signed [TRIG_W-1:0] sin_q14;
    logic [SRC_W-1:0]         src_width;
    logic [SRC_W-1:0]         src_height;
    logic [OUT_W-1:0]         out_width;
    logic [OUT_W-1:0]         out_height;
  } imrot_cfg_t;

  typedef struct packed {
    logic                  fetch;    // a fetch reads the store this cycle
    logic                  wr;       // a load writes the store this cycle
    logic                  hit;      // fetch sample falls inside the source
    logic [ADDR_BITS-1:0]  addr;
    logic [PIXEL_BITS-1:0] wdata;
  } imrot_req_t;

endpackage

@@ hw/rtl/image_rotate_nearest_top.sv @@
// top level of the nearest-neighbor rotation frame store
// depends on imrot_pkg, imrot_map and imrot_ram
//
// Takes one word per clock, loads and fetches mixed freely, and busy is low
// at all times after reset. A load writes one source pixel into the frame
// store and gives no result. A fetch maps an output pixel back through the
// rotation and returns one result word, marked by out_valid, once it has
// passed, in order, the registered centered offsets, the four rotation
// products, the bounds check and store address, and the registered store
// read. The result is shown for one cycle only; the receiver cannot
// stall it, so it must take every result as it comes. Loads and fetches
// reach the single store port in the order they were taken, so a fetch
// always sees every earlier load. Configuration may be written only while
// no fetch is in flight.
module image_rotate_nearest_top
  import imrot_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // command channel
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_func,
  input  logic [COORD_W-1:0]    in_col,
  input  logic [COORD_W-1:0]    in_row,
  input  logic [PIXEL_BITS-1:0] in_pixel_in,
  // result channel
  output logic                  out_valid,
  output logic [PIXEL_BITS-1:0] out_pixel_out,
  output logic                  out_inside_res,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  imrot_cfg_t            cfg_r;
  logic [PIXEL_BITS-1:0] clear_r;
  logic                  busy_r;
  logic                  accept;
  imrot_req_t            req;
  logic [PIXEL_BITS-1:0] rdata;
  logic                  fetch_d_r, hit_d_r;

  // busy only while reset holds
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  // configuration registers, reset to the identity rotation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cos_q14    <= TRIG_W'(16384);
      cfg_r.sin_q14    <= '0;
      cfg_r.src_width  <= SRC_W'(256);
      cfg_r.src_height <= SRC_W'(256);
      cfg_r.out_width  <= OUT_W'(256);
      cfg_r.out_height <= OUT_W'(256);
      clear_r          <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COS:   cfg_r.cos_q14    <= cfg_data[TRIG_W-1:0];
        CFG_SIN:   cfg_r.sin_q14    <= cfg_data[TRIG_W-1:0];
        CFG_SRC_W: cfg_r.src_width  <= cfg_data[SRC_W-1:0];
        CFG_SRC_H: cfg_r.src_height <= cfg_data[SRC_W-1:0];
        CFG_OUT_W: cfg_r.out_width  <= cfg_data[OUT_W-1:0];
        CFG_OUT_H: cfg_r.out_height <= cfg_data[OUT_W-1:0];
        CFG_CLEAR: clear_r          <= cfg_data[PIXEL_BITS-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // offsets, products and bounds, ending in one store access per word
  imrot_map u_map (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .func   (in_func),
    .col    (in_col),
    .row    (in_row),
    .pixel  (in_pixel_in),
    .cfg    (cfg_r),
    .req    (req)
  );

  // frame store, addressed row * side + col
  imrot_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (req.wr),
    .addr  (req.addr),
    .wdata (req.wdata),
    .rdata (rdata)
  );

  // align fetch flags with the registered read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fetch_d_r <= 1'b0;
    end else begin
      fetch_d_r <= req.fetch;
    end
    hit_d_r <= req.hit;
  end

  // outside samples give the clear value
  assign out_valid      = fetch_d_r;
  assign out_inside_res = hit_d_r;
  assign out_pixel_out  = hit_d_r ? rdata : clear_r;

endmodule

@@ hw/rtl/imrot_ram.sv @@
// generic single-port synchronous ram, registered read
// no dependencies
module imrot_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/imrot_map.sv @@
// coordinate mapping pipeline: offsets, rotation products, bounds and store address
// depends on imrot_pkg
module imrot_map
  import imrot_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  logic                  func,
  input  logic [COORD_W-1:0]    col,
  input  logic [COORD_W-1:0]    row,
  input  logic [PIXEL_BITS-1:0] pixel,
  input  imrot_cfg_t            cfg,
  output imrot_req_t            req
);

  // stage a: centered offsets
  logic                  a_fetch_r, a_wr_r;
  logic signed [D_W-1:0] a_dx_r, a_dy_r;
  logic [ADDR_BITS-1:0]  a_addr_r;
  logic [PIXEL_BITS-1:0] a_pix_r;

  // stage b: rotation products
  logic                     b_fetch_r, b_wr_r;
  logic signed [PROD_W-1:0] b_xc_r, b_ys_r, b_xs_r, b_yc_r;
  logic [ADDR_BITS-1:0]     b_addr_r;
  logic [PIXEL_BITS-1:0]    b_pix_r;

  // stage c: store request
  imrot_req_t req_r, req_nxt;

  logic signed [D_W-1:0]   dx, dy;
  logic                    load_ok;
  logic [SRC_W-1:0]        sw, sh;
  logic signed [SUM_W-1:0] x_sum, y_sum;
  logic [SUM_W-2:0]        lim_x, lim_y;
  logic                    in_x, in_y;

  assign dx = $signed({1'b0, col, 1'b0}) - $signed({1'b0, cfg.out_width});
  assign dy = $signed({1'b0, row, 1'b0}) - $signed({1'b0, cfg.out_height});
  // loads beyond the store are dropped
  assign load_ok = (col < COORD_W'(MAX_SIDE)) && (row < COORD_W'(MAX_SIDE));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_fetch_r <= 1'b0;
      a_wr_r    <= 1'b0;
      b_fetch_r <= 1'b0;
      b_wr_r    <= 1'b0;
    end else begin
      a_fetch_r <= accept && (func == FUNC_FETCH);
      a_wr_r    <= accept && (func == FUNC_LOAD) && load_ok;
      b_fetch_r <= a_fetch_r;
      b_wr_r    <= a_wr_r;
    end
  end

  always_ff @(posedge clk) begin
    a_dx_r   <= dx;
    a_dy_r   <= dy;
    a_addr_r <= {row[SIDE_BITS-1:0], col[SIDE_BITS-1:0]};
    a_pix_r  <= pixel;
    b_xc_r   <= a_dx_r * cfg.cos_q14;
    b_ys_r   <= a_dy_r * cfg.sin_q14;
    b_xs_r   <= a_dx_r * cfg.sin_q14;
    b_yc_r   <= a_dy_r * cfg.cos_q14;
    b_addr_r <= a_addr_r;
    b_pix_r  <= a_pix_r;
  end

  // oversized source sides saturate to the store side
  assign sw = (cfg.src_width  > SRC_W'(MAX_SIDE)) ? SRC_W'(MAX_SIDE) : cfg.src_width;
  assign sh = (cfg.src_height > SRC_W'(MAX_SIDE)) ? SRC_W'(MAX_SIDE) : cfg.src_height;

  assign x_sum = SUM_W'(b_xc_r) - SUM_W'(b_ys_r)
               + $signed(SUM_W'({sw, {TRIG_FRAC_BITS{1'b0}}}));
  assign y_sum = SUM_W'(b_xs_r) + SUM_W'(b_yc_r)
               + $signed(SUM_W'({sh, {TRIG_FRAC_BITS{1'b0}}}));
  assign lim_x = (SUM_W-1)'({sw, {(TRIG_FRAC_BITS+1){1'b0}}});
  assign lim_y = (SUM_W-1)'({sh, {(TRIG_FRAC_BITS+1){1'b0}}});
  assign in_x  = !x_sum[SUM_W-1] && (x_sum[SUM_W-2:0] < lim_x);
  assign in_y  = !y_sum[SUM_W-1] && (y_sum[SUM_W-2:0] < lim_y);

  always_comb begin
    req_nxt        = '0;
    req_nxt.fetch  = b_fetch_r;
    req_nxt.wr     = b_wr_r;
    req_nxt.hit    = in_x && in_y;
    req_nxt.wdata  = b_pix_r;
    if (b_fetch_r) begin
      req_nxt.addr = {y_sum[TRIG_FRAC_BITS+1 +: SIDE_BITS],
                      x_sum[TRIG_FRAC_BITS+1 +: SIDE_BITS]};
    end else begin
      req_nxt.addr = b_addr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r.fetch <= 1'b0;
      req_r.wr    <= 1'b0;
    end else begin
      req_r.fetch <= req_nxt.fetch;
      req_r.wr    <= req_nxt.wr;
    end
    req_r.hit    <= req_nxt.hit;
    req_r.addr   <= req_nxt.addr;
    req_r.wdata  <= req_nxt.wdata;
  end

  assign req = req_r;

endmodule
